// ===== hw/rtl/max_pool_3x3_stride2_defines.svh =====
// assertion macros shared by the max pooling rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef MAX_POOL_3X3_STRIDE2_DEFINES_SVH
`define MAX_POOL_3X3_STRIDE2_DEFINES_SVH

`ifndef SYNTHESIS

// checked property, gated off while reset is asserted
`define MP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked property, also active during reset
`define MP_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define MP_ASSERT(label, clk, rst_n, prop, msg)

`define MP_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// ===== hw/rtl/mp3s2_pkg.sv =====
// constants shared by the 3x3 stride 2 max pooling block
// no dependencies
package mp3s2_pkg;

    // default geometry and word width
    localparam int DEF_MAX_MAP_SIZE = 256;
    localparam int DEF_DATA_WIDTH   = 16;

    // configuration register
    localparam int          CFG_W          = 9;
    localparam logic [8:0]  MAP_SIZE_RESET = 9'd55;

    // window geometry
    localparam int MIN_MAP_SIZE  = 3;
    localparam int FIRST_WIN_END = 2;

endpackage

// ===== hw/rtl/mp3s2_line_ram.sv =====
// line buffer ram: one write port, one read port, registered read data
// depends on mp3s2_pkg for default sizes
module mp3s2_line_ram #(
    parameter int DEPTH = mp3s2_pkg::DEF_MAX_MAP_SIZE,
    parameter int WIDTH = 2 * mp3s2_pkg::DEF_DATA_WIDTH
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    import mp3s2_pkg::*;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // read port, registered, holds between reads
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/max_pool_3x3_stride2.sv =====
// 3x3 stride 2 max pooling over raster-order square maps.
// a result passes through stage one and the output register before it is offered.
// throughput: one sample per cycle while the output is not blocked, set by the line
// ram read-modify-write (read on request, write back when stage one retires).
// reset (synchronous, active low) clears counters, column history and map_size
// to 55; the line ram is not cleared and needs no clearing pass.
`include "max_pool_3x3_stride2_defines.svh"

module max_pool_3x3_stride2 #(
    parameter int MAX_MAP_SIZE = mp3s2_pkg::DEF_MAX_MAP_SIZE,
    parameter int DATA_WIDTH   = mp3s2_pkg::DEF_DATA_WIDTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mp3s2_pkg::CFG_W-1:0]    cfg_map_size,
    // sample stream in
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [DATA_WIDTH-1:0]   s_sample,
    // pooled stream out
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [DATA_WIDTH-1:0]   m_pooled,
    output logic                           m_map_done
);
    import mp3s2_pkg::*;

    localparam int CNT_W = $clog2(MAX_MAP_SIZE);
    localparam int EFF_W = $clog2(MAX_MAP_SIZE + 1);
    localparam int CMP_W = (EFF_W > CFG_W) ? EFF_W : CFG_W;
    localparam int WORD_W = 2 * DATA_WIDTH;

    // configuration and position state
    logic [CFG_W-1:0] map_size_reg;
    logic [CNT_W-1:0] row_count_reg, row_count_next;
    logic [CNT_W-1:0] col_count_reg, col_count_next;

    // stage one: sample waiting for its line ram word
    logic                         s1_valid_reg;
    logic signed [DATA_WIDTH-1:0] s1_sample_reg;
    logic [CNT_W-1:0]             s1_addr_reg;
    logic                         s1_emit_reg;
    logic                         s1_last_reg;

    // column history
    logic signed [DATA_WIDTH-1:0] hist0_reg, hist1_reg;

    // output register
    logic                         m_valid_reg;
    logic signed [DATA_WIDTH-1:0] m_pooled_reg;
    logic                         m_map_done_reg;

    // derived combinational signals
    logic [CMP_W-1:0] size_ext;
    logic [EFF_W-1:0] eff_size, size_m1, last_end, row_ext, col_ext;
    logic             win_hit, win_last, col_wrap, row_wrap;
    logic             in_accept, s1_done, out_free;

    logic                         ram_we, ram_re;
    logic [CNT_W-1:0]             ram_waddr, ram_raddr;
    logic [WORD_W-1:0]            ram_wdata, ram_rdata;
    logic signed [DATA_WIDTH-1:0] rd_prev, rd_prev2, max_rows, colmax, hist_max, pooled;

    assign cfg_ready = 1'b1;

    // effective size, clamped to the supported range
    always_comb begin
        size_ext = CMP_W'(map_size_reg);
        if (size_ext < CMP_W'(MIN_MAP_SIZE)) begin
            eff_size = EFF_W'(MIN_MAP_SIZE);
        end else if (size_ext > CMP_W'(MAX_MAP_SIZE)) begin
            eff_size = EFF_W'(MAX_MAP_SIZE);
        end else begin
            eff_size = EFF_W'(size_ext);
        end
        size_m1  = eff_size - EFF_W'(1);
        last_end = {size_m1[EFF_W-1:1], 1'b0};
    end

    // window detection on the incoming position
    always_comb begin
        row_ext  = EFF_W'(row_count_reg);
        col_ext  = EFF_W'(col_count_reg);
        win_hit  = (row_ext >= EFF_W'(FIRST_WIN_END)) && !row_ext[0] &&
                   (col_ext >= EFF_W'(FIRST_WIN_END)) && !col_ext[0] &&
                   (row_ext <= last_end) && (col_ext <= last_end);
        win_last = (row_ext == last_end) && (col_ext == last_end);
        col_wrap = (col_ext >= size_m1);
        row_wrap = (row_ext >= size_m1);
    end

    // handshake: stage one finishes unless its result is blocked
    assign out_free  = !m_valid_reg || m_ready;
    assign s1_done   = s1_valid_reg && (!s1_emit_reg || out_free);
    assign s_ready   = !s1_valid_reg || s1_done;
    assign in_accept = s_valid && s_ready;

    // position counters
    always_comb begin
        row_count_next = row_count_reg;
        col_count_next = col_count_reg;
        if (in_accept) begin
            if (col_wrap) begin
                col_count_next = '0;
                row_count_next = row_wrap ? '0 : CNT_W'(row_count_reg + CNT_W'(1));
            end else begin
                col_count_next = CNT_W'(col_count_reg + CNT_W'(1));
            end
        end
    end

    // line ram: read on request, write back when stage one retires
    assign ram_re    = in_accept;
    assign ram_raddr = col_count_reg;
    assign ram_we    = s1_done;
    assign ram_waddr = s1_addr_reg;
    assign ram_wdata = {rd_prev, s1_sample_reg};

    mp3s2_line_ram #(
        .DEPTH (MAX_MAP_SIZE),
        .WIDTH (WORD_W)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // column maximum and window maximum
    always_comb begin
        rd_prev2 = ram_rdata[WORD_W-1:DATA_WIDTH];
        rd_prev  = ram_rdata[DATA_WIDTH-1:0];
        max_rows = (rd_prev2 >= rd_prev) ? rd_prev2 : rd_prev;
        colmax   = (max_rows >= s1_sample_reg) ? max_rows : s1_sample_reg;
        hist_max = (hist0_reg >= hist1_reg) ? hist0_reg : hist1_reg;
        pooled   = (colmax >= hist_max) ? colmax : hist_max;
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_size_reg  <= MAP_SIZE_RESET;
            row_count_reg <= '0;
            col_count_reg <= '0;
            s1_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
            hist0_reg     <= '0;
            hist1_reg     <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                map_size_reg <= cfg_map_size;
            end
            row_count_reg <= row_count_next;
            col_count_reg <= col_count_next;
            if (in_accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_done) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_done) begin
                hist1_reg <= hist0_reg;
                hist0_reg <= colmax;
            end
            if (s1_done && s1_emit_reg) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            s1_sample_reg <= s_sample;
            s1_addr_reg   <= col_count_reg;
            s1_emit_reg   <= win_hit;
            s1_last_reg   <= win_last;
        end
        if (s1_done && s1_emit_reg) begin
            m_pooled_reg   <= pooled;
            m_map_done_reg <= s1_last_reg;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_pooled   = m_pooled_reg;
    assign m_map_done = m_map_done_reg;

    // write-back never lands on the column being read
    `MP_ASSERT(a_no_ram_collision, aclk, aresetn, (ram_we && ram_re) |-> (ram_waddr != ram_raddr), "line ram read and write hit the same column")
    // a blocked stage one keeps its request and address
    `MP_ASSERT(a_s1_hold, aclk, aresetn, (s1_valid_reg && !s1_done) |=> (s1_valid_reg && $stable(s1_addr_reg) && $stable(s1_emit_reg)), "stage one lost its request while stalled")
    // input only stalls behind a busy stage one
    `MP_ASSERT(a_ready_cause, aclk, aresetn, !s_ready |-> (s1_valid_reg && s1_emit_reg && m_valid_reg && !m_ready), "input stalled without a blocked result")
    // write-back happens exactly once per retiring request
    `MP_ASSERT(a_wb_once, aclk, aresetn, (ram_we && !in_accept) |=> !ram_we, "line ram written twice for one request")

endmodule

// ===== tb/max_pool_3x3_stride2_tb.sv =====
// self-checking testbench for the 3x3 stride 2 max pooling block
// depends on mp3s2_pkg and max_pool_3x3_stride2; drives random and directed maps
module max_pool_3x3_stride2_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mp3s2_pkg::*;

    localparam int DW            = DEF_DATA_WIDTH;
    localparam int MAXS          = DEF_MAX_MAP_SIZE;
    localparam int STRIDE        = 2;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 4000;
    localparam int END_WAIT      = 2000;
    localparam int RAND_ITEMS    = 1520;
    localparam int HOLD_CYCLES   = 400;
    localparam int PRESS_PHASE   = 4;
    localparam int PAUSE_PHASE   = 6;

    localparam logic signed [DW-1:0] MIN_WORD = {1'b1, {(DW-1){1'b0}}};
    localparam logic signed [DW-1:0] MAX_WORD = {1'b0, {(DW-1){1'b1}}};

    typedef struct packed {
        logic signed [DW-1:0] pooled;
        logic                 map_done;
    } pool_res_t;

    // dut ports, inputs known from time zero
    logic                   aclk         = 1'b0;
    logic                   aresetn      = 1'b0;
    logic                   cfg_valid    = 1'b0;
    logic                   cfg_ready;
    logic [CFG_W-1:0]       cfg_map_size = '0;
    logic                   s_valid      = 1'b0;
    logic                   s_ready;
    logic signed [DW-1:0]   s_sample     = '0;
    logic                   m_valid;
    logic                   m_ready      = 1'b0;
    logic signed [DW-1:0]   m_pooled;
    logic                   m_map_done;

    // stimulus and scoreboard bookkeeping
    logic signed [DW-1:0]   sample_q [$];
    pool_res_t              pooled_q [$];
    int unsigned            queued       = 0;
    int unsigned            samples_in   = 0;
    int unsigned            results_out  = 0;
    int unsigned            maps_closed  = 0;
    int unsigned            cfg_writes   = 0;
    int unsigned            errors       = 0;
    int unsigned            quiet_cycles = 0;
    int                     tx_idle_pct  = 0;
    int                     rx_stall_pct = 0;
    int                     rx_hold_req  = 0;
    int                     rx_hold_left = 0;
    pool_res_t              want;

    // shadow of the pooling datapath
    logic [CFG_W-1:0]       size_reg     = MAP_SIZE_RESET;
    logic signed [DW-1:0]   row_m1 [MAXS];
    logic signed [DW-1:0]   row_m2 [MAXS];
    logic [1:0]             col_writes [MAXS];
    logic signed [DW-1:0]   colmax_d1    = '0;
    logic signed [DW-1:0]   colmax_d2    = '0;
    int unsigned            pos_row      = 0;
    int unsigned            pos_col      = 0;

    initial begin
        for (int i = 0; i < MAXS; i++) begin
            row_m1[i]     = '0;
            row_m2[i]     = '0;
            col_writes[i] = '0;
        end
    end

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    max_pool_3x3_stride2 #(
        .MAX_MAP_SIZE (MAXS),
        .DATA_WIDTH   (DW)
    ) uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_map_size (cfg_map_size),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample     (s_sample),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_pooled     (m_pooled),
        .m_map_done   (m_map_done)
    );

    function automatic int unsigned clamp_size(input logic [CFG_W-1:0] s);
        if (s < MIN_MAP_SIZE) return MIN_MAP_SIZE;
        if (s > MAXS) return MAXS;
        return s;
    endfunction

    function automatic logic signed [DW-1:0] smax(input logic signed [DW-1:0] a,
                                                   input logic signed [DW-1:0] b);
        return (a >= b) ? a : b;
    endfunction

    // number of leading columns whose line entries have both been written
    function automatic int unsigned filled_columns();
        int unsigned n;
        n = 0;
        while (n < MAXS && col_writes[n] == 2'd2) n++;
        return n;
    endfunction

    // one accepted sample: column max, window max, line and counter update
    function automatic void pool_accept(input logic signed [DW-1:0] x);
        int unsigned          sz;
        int unsigned          last_end;
        int unsigned          ci;
        logic signed [DW-1:0] cm;
        pool_res_t            res;
        sz       = clamp_size(size_reg);
        last_end = ((sz - MIN_MAP_SIZE) / STRIDE) * STRIDE + FIRST_WIN_END;
        ci       = (pos_col < MAXS) ? pos_col : MAXS - 1;
        cm       = smax(smax(row_m2[ci], row_m1[ci]), x);
        if (pos_row >= FIRST_WIN_END && (pos_row % STRIDE) == 0 &&
            pos_col >= FIRST_WIN_END && (pos_col % STRIDE) == 0 &&
            pos_row <= last_end && pos_col <= last_end) begin
            res.pooled   = smax(cm, smax(colmax_d1, colmax_d2));
            res.map_done = (pos_row == last_end && pos_col == last_end);
            pooled_q.push_back(res);
        end
        colmax_d2  = colmax_d1;
        colmax_d1  = cm;
        row_m2[ci] = row_m1[ci];
        row_m1[ci] = x;
        if (col_writes[ci] != 2'd2) col_writes[ci] = col_writes[ci] + 2'd1;
        // raster position, wrapping at the end of the row and of the map
        if (pos_col >= sz - 1) begin
            pos_col = 0;
            pos_row = (pos_row >= sz - 1) ? 0 : pos_row + 1;
        end else begin
            pos_col = pos_col + 1;
        end
    endfunction

    function automatic logic signed [DW-1:0] rand_sample();
        logic signed [DW-1:0] w;
        int                   v;
        case ($urandom_range(0, 9))
            0: w = MIN_WORD;
            1: w = MAX_WORD;
            2, 3: begin
                // narrow spread so that ties and near ties are common
                v = $urandom_range(0, 8);
                w = DW'(v - 4);
            end
            default: w = DW'($urandom());
        endcase
        return w;
    endfunction

    function automatic void queue_one(input logic signed [DW-1:0] v);
        sample_q.push_back(v);
        queued++;
    endfunction

    task automatic queue_samples(input int n);
        @(negedge aclk);
        repeat (n) queue_one(rand_sample());
    endtask

    task automatic set_mode(input int tx_pct, input int rx_pct);
        @(negedge aclk);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
    endtask

    // wait for every sample taken and every result seen, then let the pipe settle
    task automatic drain();
        while (samples_in != queued || pooled_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_map_size(input logic [CFG_W-1:0] v);
        @(posedge aclk);
        cfg_valid    <= 1'b1;
        cfg_map_size <= v;
        do @(posedge aclk); while (!cfg_ready);
        size_reg = v;
        cfg_writes++;
        cfg_valid <= 1'b0;
    endtask

    // sample driver: holds a request until it is taken
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                pool_accept(s_sample);
                samples_in++;
            end
            if (!s_valid || s_ready) begin
                if (sample_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                    s_valid  <= 1'b1;
                    s_sample <= sample_q.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_out++;
                if (m_map_done) maps_closed++;
                if (pooled_q.size() == 0) begin
                    errors++;
                    $display("%0t: result with nothing expected, pooled=%0d map_done=%0b",
                             $time, m_pooled, m_map_done);
                end else begin
                    want = pooled_q.pop_front();
                    if (m_pooled !== want.pooled) begin
                        errors++;
                        $display("%0t: pooled expected %0d actual %0d",
                                 $time, $signed(want.pooled), m_pooled);
                    end
                    if (m_map_done !== want.map_done) begin
                        errors++;
                        $display("%0t: map_done expected %0b actual %0b",
                                 $time, want.map_done, m_map_done);
                    end
                end
            end
            if (rx_hold_req != 0) begin
                rx_hold_left = rx_hold_req;
                rx_hold_req  = 0;
            end
            if (rx_hold_left != 0) begin
                rx_hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
            end
        end
    end

    // watchdog on cycles with no request taken on any channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: watchdog, no request taken for %0d cycles, %0d results pending",
                     $time, quiet_cycles, pooled_q.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // test sequence
    initial begin
        int          p;
        int          sz_val;
        int          eff;
        int          n;
        int          width;
        int unsigned rand_items;
        int unsigned waited;
        rand_items = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // directed: size below range acts as 3, flat minimum map, then a wrap
        // into a second map with the maximum in its first corner
        write_map_size('0);
        @(negedge aclk);
        repeat (9) queue_one(MIN_WORD);
        queue_one(MAX_WORD);
        repeat (8) queue_one(MIN_WORD);
        drain();

        // directed: size shrunk mid-map, counter at the new row end wraps
        write_map_size(CFG_W'(4));
        @(negedge aclk);
        repeat (6) queue_one(DW'(-1));
        drain();
        write_map_size(CFG_W'(3));
        @(negedge aclk);
        queue_one(DW'(-1));
        queue_one(MIN_WORD);
        queue_one('0);
        queue_one(DW'(-2));
        drain();

        // size above range acts as the largest map; a few rows only
        write_map_size({CFG_W{1'b1}});
        set_mode(19, 19);
        n = 2 * MAXS + 41;
        queue_samples(n);
        rand_items += n;
        drain();

        // random phases over the idling patterns, always reaching the pause phase
        for (p = 0; rand_items < RAND_ITEMS || p <= PAUSE_PHASE; p++) begin
            width = filled_columns();
            if (pos_row == 0 && pos_col == 0) begin
                sz_val = $urandom_range(0, 13);
            end else begin
                // mid-map change: stay within columns already filled twice
                sz_val = $urandom_range(0, (width < 13) ? width : 13);
            end
            write_map_size(CFG_W'(sz_val));
            eff = clamp_size(CFG_W'(sz_val));
            n   = eff * eff * (1 + $urandom_range(0, 120 / (eff * eff)));
            if ($urandom_range(0, 2) == 0) n += $urandom_range(1, eff * eff - 1);
            case (p % 4)
                0: set_mode(0, 0);
                1: set_mode(85, 0);
                2: set_mode(0, 85);
                default: set_mode(19, 19);
            endcase
            if (p == PRESS_PHASE) begin
                // receiver shut for a long stretch while samples keep coming
                set_mode(0, 0);
                rx_hold_req = HOLD_CYCLES;
                n += 200;
                queue_samples(n);
            end else if (p == PAUSE_PHASE) begin
                // sender stops halfway until every result is back
                queue_samples(n / 2);
                drain();
                queue_samples(n - n / 2);
            end else begin
                queue_samples(n);
            end
            rand_items += n;
            drain();
        end

        // end of run: all samples taken, then wait for stragglers
        while (samples_in != queued) @(posedge aclk);
        waited = 0;
        while (pooled_q.size() != 0 && waited < END_WAIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (pooled_q.size() != 0) begin
            errors++;
            $display("%0t: %0d expected results never arrived", $time, pooled_q.size());
        end
        $display("covered %0d samples, %0d pooled results, %0d map ends, %0d size writes",
                 samples_in, results_out, maps_closed, cfg_writes);
        $display("sizes from below range to above range, mid-map changes, stalls both sides");
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/mp3s2_pkg.sv
hw/rtl/mp3s2_line_ram.sv
hw/rtl/max_pool_3x3_stride2.sv
tb/max_pool_3x3_stride2_tb.sv
